// ===== sv/fspa_pkg.sv =====
// package: types and constants of the fit-strategy pool allocator
`timescale 1ns / 1ps
package fspa_pkg;
    localparam int POOL_ADDR_BITS = 16;
    localparam int OP_W   = 2;
    localparam int REQ_W  = POOL_ADDR_BITS + 1;
    localparam int ADDR_W = POOL_ADDR_BITS;
    localparam int CNT_W  = 7;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADREQ  = 2'd3;

    localparam logic [2:0] FIT_NONE  = 3'd0;
    localparam logic [2:0] FIT_FIRST = 3'd1;
    localparam logic [2:0] FIT_BEST  = 3'd2;
    localparam logic [2:0] FIT_WORST = 3'd3;
    localparam logic [2:0] FIT_NEXT  = 3'd4;

    localparam logic CFG_STRATEGY = 1'b0;
    localparam logic CFG_POOL     = 1'b1;

    // cell-wide control broadcast along the row
    typedef enum logic [2:0] {
        CMD_HOLD  = 3'b001,
        CMD_INS   = 3'b010,   // open a gap: cells at or above pos take left neighbor
        CMD_DEL   = 3'b100    // close a gap: cells at or above pos take right neighbor
    } cell_cmd_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_EDIT  = 7'b0001000,
        S_MERGE = 7'b0010000,
        S_STAT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;
endpackage

// ===== sv/fspa_if.sv =====
// valid/ready channel interfaces of the allocator
`timescale 1ns / 1ps
interface fspa_req_if;
    import fspa_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] address;
    logic [REQ_W-1:0]  threshold;
    modport source (output valid, op, request_bytes, address, threshold, input ready);
    modport sink   (input valid, op, request_bytes, address, threshold, output ready);
endinterface

interface fspa_rsp_if;
    import fspa_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_start;
    logic [CNT_W-1:0]  hole_count;
    logic [REQ_W-1:0]  bytes_allocated;
    logic [REQ_W-1:0]  bytes_free;
    logic [REQ_W-1:0]  largest_hole;
    logic [CNT_W-1:0]  small_hole_count;
    logic              probe_allocated;
    modport source (output valid, status, block_start, hole_count, bytes_allocated,
                    bytes_free, largest_hole, small_hole_count, probe_allocated,
                    input ready);
    modport sink   (input valid, status, block_start, hole_count, bytes_allocated,
                    bytes_free, largest_hole, small_hole_count, probe_allocated,
                    output ready);
endinterface

// ===== sv/fspa_cell.sv =====
// one table slot: start, size, taken; shifts with its neighbors and rotates for scans
`timescale 1ns / 1ps
module fspa_cell
    import fspa_pkg::*;
#(
    parameter int AW = 16,
    parameter int SW = 17
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          is_first,
    input  logic          rot,         // ring rotation, one step toward index 0
    input  cell_cmd_t     cmd,
    input  logic          at_or_above, // this index >= edit position
    input  logic          load,        // direct write
    input  logic [AW-1:0] ld_start,
    input  logic [SW-1:0] ld_size,
    input  logic          ld_taken,
    input  logic [AW-1:0] left_start,
    input  logic [SW-1:0] left_size,
    input  logic          left_taken,
    input  logic [AW-1:0] right_start,
    input  logic [SW-1:0] right_size,
    input  logic          right_taken,
    output logic [AW-1:0] start,
    output logic [SW-1:0] size,
    output logic          taken
);
    logic [AW-1:0] start_reg, start_next;
    logic [SW-1:0] size_reg, size_next;
    logic          taken_reg, taken_next;

    always_comb
    begin
        start_next = start_reg;
        size_next  = size_reg;
        taken_next = taken_reg;
        if (load)
        begin
            start_next = ld_start;
            size_next  = ld_size;
            taken_next = ld_taken;
        end
        else if (rot)
        begin
            start_next = right_start;
            size_next  = right_size;
            taken_next = right_taken;
        end
        else if (cmd == CMD_INS && at_or_above)
        begin
            start_next = left_start;
            size_next  = left_size;
            taken_next = left_taken;
        end
        else if (cmd == CMD_DEL && at_or_above)
        begin
            start_next = right_start;
            size_next  = right_size;
            taken_next = right_taken;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            size_reg  <= is_first ? SW'(1 << AW) : '0;
            taken_reg <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            size_reg  <= size_next;
            taken_reg <= taken_next;
        end
    end

    assign start = start_reg;
    assign size  = size_reg;
    assign taken = taken_reg;
endmodule

// ===== sv/fit_strategy_pool_allocator.sv =====
// Fit-strategy pool allocator: a row of MAX_SEGMENTS segment cells covering a byte pool,
// kept in address order. The live entries rotate one cell per cycle past a single compare
// unit at cell 0. Allocate and free take a scan pass over the live entries (S_SCAN) to
// find the fitting or matching segment and its neighbors, an extra step (S_DEC) for next
// fit, an edit step (S_EDIT), S_MERGE steps for a split or a free with its merges,
// then a statistics pass (S_STAT) and an output step (S_OUT). Init and status skip the
// scan and go straight to the statistics pass. A finished word waits in the output
// register and blocks the input; the next word is taken in the cycle after the result
// leaves.
`timescale 1ns / 1ps
module fit_strategy_pool_allocator
    import fspa_pkg::*;
#(
    parameter int MAX_SEGMENTS   = 64
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [REQ_W-1:0]         cfg_data,
    fspa_req_if.sink                 req,
    fspa_rsp_if.source               rsp
);
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = POOL_ADDR_BITS;
    localparam int SW = POOL_ADDR_BITS + 1;

    logic [2:0]    strat_reg;
    logic [REQ_W-1:0] pool_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strat_reg <= FIT_NONE;
            pool_reg  <= REQ_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STRATEGY: strat_reg <= cfg_data[2:0];
                CFG_POOL:     pool_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // cell row
    logic [AW-1:0] c_start [MAX_SEGMENTS];
    logic [SW-1:0] c_size  [MAX_SEGMENTS];
    logic          c_taken [MAX_SEGMENTS];
    logic          rot;
    cell_cmd_t     cmd;
    logic [IW-1:0] pos;            // edit position
    logic          ld_any;
    logic [IW-1:0] ld_idx;
    logic [AW-1:0] ld_start;
    logic [SW-1:0] ld_size;
    logic          ld_taken;
    logic          clear_row;

    // rotation over count entries: cell count-1 takes cell 0
    logic [NW-1:0] count_reg, count_next;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            logic [AW-1:0] rs;
            logic [SW-1:0] rz;
            logic          rt;
            logic          ld;
            always_comb
            begin
                if (rot && (NW'(g) == count_reg - NW'(1)))
                begin
                    rs = c_start[0]; rz = c_size[0]; rt = c_taken[0];
                end
                else if (g == MAX_SEGMENTS - 1)
                begin
                    rs = '0; rz = '0; rt = 1'b0;
                end
                else
                begin
                    rs = c_start[(g+1) % MAX_SEGMENTS];
                    rz = c_size[(g+1) % MAX_SEGMENTS];
                    rt = c_taken[(g+1) % MAX_SEGMENTS];
                end
                ld = clear_row || (ld_any && ld_idx == IW'(g));
            end
            fspa_cell #(.AW(AW), .SW(SW)) u_cell (
                .clk(clk), .rst_n(rst_n), .is_first(g == 0),
                .rot(rot && (NW'(g) < count_reg)), .cmd(cmd),
                .at_or_above(IW'(g) >= pos), .load(ld),
                .ld_start(clear_row ? '0 : ld_start),
                .ld_size(clear_row ? ((g == 0) ? ld_size : '0) : ld_size),
                .ld_taken(clear_row ? 1'b0 : ld_taken),
                .left_start(c_start[(g+MAX_SEGMENTS-1) % MAX_SEGMENTS]),
                .left_size(c_size[(g+MAX_SEGMENTS-1) % MAX_SEGMENTS]),
                .left_taken(c_taken[(g+MAX_SEGMENTS-1) % MAX_SEGMENTS]),
                .right_start(rs), .right_size(rz), .right_taken(rt),
                .start(c_start[g]), .size(c_size[g]), .taken(c_taken[g]));
        end
    endgenerate

    // control
    state_t        state_reg, state_next;
    logic [1:0]    op_reg;
    logic [REQ_W-1:0] rq_reg, thr_reg;
    logic [AW-1:0] addr_reg;
    logic [IW-1:0] cur_reg, cur_next;
    logic [NW-1:0] k_reg, k_next;           // scan step, also table index of cell 0
    logic          have_reg, have_next;
    logic [IW-1:0] fnd_reg, fnd_next;
    logic [SW-1:0] fsz_reg, fsz_next;
    logic [AW-1:0] fst_reg, fst_next;
    logic [1:0]    stat_reg, stat_next;
    logic [AW-1:0] bs_reg, bs_next;
    logic [1:0]    mstep_reg, mstep_next;
    logic [CNT_W-1:0] holes_reg, holes_next, small_reg, small_next;
    logic [REQ_W-1:0] ab_reg, ab_next, fb_reg, fb_next, lg_reg, lg_next;
    logic          probe_reg, probe_next;
    logic          ovalid_reg;
    // neighbors of the entry being freed, caught as they pass cell 0
    logic [AW-1:0] pvs_reg, pvs_next;
    logic [SW-1:0] pvz_reg, pvz_next;
    logic          pvt_reg, pvt_next;
    logic [AW-1:0] ls_reg, ls_next;
    logic [SW-1:0] lz_reg, lz_next;
    logic          lfree_reg, lfree_next;
    logic [SW-1:0] rz_reg, rz_next;
    logic          rfree_reg, rfree_next;
    logic          grab_reg, grab_next;

    logic [REQ_W-1:0] pool_sat;
    logic [IW-1:0]    k_idx;
    logic [REQ_W-1:0] sz0;
    logic             fits0;
    logic [SW:0]      pend;

    assign pool_sat = (pool_reg > REQ_W'(1 << AW)) ? REQ_W'(1 << AW) : pool_reg;
    assign k_idx    = k_reg[IW-1:0];
    assign sz0      = REQ_W'(c_size[0]);
    assign fits0    = !c_taken[0] && (sz0 >= rq_reg);
    assign pend     = {1'b0, c_size[0]} + (SW+1)'(c_start[0]);

    assign req.ready = (state_reg == S_IDLE) && !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        have_next  = have_reg;
        fnd_next   = fnd_reg;
        fsz_next   = fsz_reg;
        fst_next   = fst_reg;
        stat_next  = stat_reg;
        bs_next    = bs_reg;
        mstep_next = mstep_reg;
        holes_next = holes_reg;
        small_next = small_reg;
        ab_next    = ab_reg;
        fb_next    = fb_reg;
        lg_next    = lg_reg;
        probe_next = probe_reg;
        pvs_next   = pvs_reg;
        pvz_next   = pvz_reg;
        pvt_next   = pvt_reg;
        ls_next    = ls_reg;
        lz_next    = lz_reg;
        lfree_next = lfree_reg;
        rz_next    = rz_reg;
        rfree_next = rfree_reg;
        grab_next  = grab_reg;
        rot        = 1'b0;
        cmd        = CMD_HOLD;
        pos        = '0;
        ld_any     = 1'b0;
        ld_idx     = '0;
        ld_start   = '0;
        ld_size    = '0;
        ld_taken   = 1'b0;
        clear_row  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    k_next    = '0;
                    have_next = 1'b0;
                    stat_next = ST_OK;
                    bs_next   = '0;
                    lfree_next = 1'b0;
                    rfree_next = 1'b0;
                    grab_next  = 1'b0;
                    if (req.op == OP_INIT)
                    begin
                        clear_row  = 1'b1;
                        ld_size    = SW'(pool_sat);
                        count_next = NW'(1);
                        cur_next   = '0;
                        state_next = S_STAT;
                    end
                    else if (req.op == OP_STATUS)
                        state_next = S_STAT;
                    else if (req.op == OP_ALLOC && req.request_bytes == '0)
                    begin
                        stat_next  = ST_BADREQ;
                        state_next = S_STAT;
                    end
                    else if (req.op == OP_ALLOC &&
                             !(strat_reg == FIT_FIRST || strat_reg == FIT_BEST ||
                               strat_reg == FIT_WORST || strat_reg == FIT_NEXT))
                    begin
                        stat_next  = ST_NOFIT;
                        state_next = S_STAT;
                    end
                    else
                        state_next = S_SCAN;
                    holes_next = '0;
                    small_next = '0;
                    ab_next    = '0;
                    fb_next    = '0;
                    lg_next    = '0;
                    probe_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // cell 0 holds table entry k
                if (k_reg < count_reg)
                begin
                    if (op_reg == OP_FREE)
                    begin
                        // right neighbor passes cell 0 in the cycle after the match
                        if (grab_reg)
                        begin
                            rfree_next = !c_taken[0];
                            rz_next    = c_size[0];
                            grab_next  = 1'b0;
                        end
                        if (!have_reg && (SW'(c_start[0]) == SW'(addr_reg)) &&
                            c_taken[0])
                        begin
                            have_next  = 1'b1;
                            fnd_next   = k_idx;
                            fst_next   = c_start[0];
                            fsz_next   = c_size[0];
                            lfree_next = (k_reg != '0) && !pvt_reg;
                            ls_next    = pvs_reg;
                            lz_next    = pvz_reg;
                            grab_next  = 1'b1;
                        end
                        pvs_next = c_start[0];
                        pvz_next = c_size[0];
                        pvt_next = c_taken[0];
                    end
                    else if (fits0)
                    begin
                        unique case (strat_reg)
                            FIT_BEST:
                                if (!have_reg || c_size[0] < fsz_reg)
                                begin
                                    have_next = 1'b1; fnd_next = k_idx;
                                    fsz_next = c_size[0]; fst_next = c_start[0];
                                end
                            FIT_WORST:
                                if (!have_reg || c_size[0] > fsz_reg)
                                begin
                                    have_next = 1'b1; fnd_next = k_idx;
                                    fsz_next = c_size[0]; fst_next = c_start[0];
                                end
                            FIT_NEXT:
                                ;
                            default:
                                if (!have_reg)
                                begin
                                    have_next = 1'b1; fnd_next = k_idx;
                                    fsz_next = c_size[0]; fst_next = c_start[0];
                                end
                        endcase
                    end
                    rot    = 1'b1;
                    k_next = k_reg + NW'(1);
                end
                else
                    state_next = (strat_reg == FIT_NEXT && op_reg == OP_ALLOC) ?
                                 S_DEC : S_EDIT;
                if (strat_reg == FIT_NEXT && op_reg == OP_ALLOC)
                begin
                    // next fit wants the first fit at or after the cursor in ring order;
                    // take a later ring position only when nothing earlier was found
                    if (k_reg < count_reg && fits0)
                    begin
                        // ring order of entry k relative to cursor
                        if (!have_reg ||
                            ((k_idx >= cur_reg) && (fnd_reg < cur_reg)) ||
                            ((k_idx >= cur_reg) == (fnd_reg >= cur_reg) &&
                             k_idx < fnd_reg))
                        begin
                            have_next = 1'b1; fnd_next = k_idx;
                            fsz_next = c_size[0]; fst_next = c_start[0];
                        end
                    end
                end
            end
            S_DEC:
                state_next = S_EDIT;
            S_EDIT:
            begin
                state_next = S_STAT;
                k_next     = '0;
                if (!have_reg)
                    stat_next = (op_reg == OP_FREE) ? ST_BADREQ : ST_NOFIT;
                else if (op_reg == OP_ALLOC)
                begin
                    if (fsz_reg > SW'(rq_reg))
                    begin
                        if (count_reg >= NW'(MAX_SEGMENTS))
                            stat_next = ST_FULL;
                        else
                        begin
                            // widen: entries above fnd move up, fnd+1 gets the remainder
                            state_next = S_MERGE;
                            mstep_next = 2'd3;
                            cmd        = CMD_INS;
                            pos        = fnd_reg + IW'(1);
                            count_next = count_reg + NW'(1);
                            if (cur_reg > fnd_reg)
                                cur_next = cur_reg + IW'(1);
                            if (strat_reg == FIT_NEXT)
                                cur_next = fnd_reg + IW'(1);
                            bs_next = fst_reg;
                        end
                    end
                    else
                    begin
                        ld_any   = 1'b1;
                        ld_idx   = fnd_reg;
                        ld_start = fst_reg;
                        ld_size  = fsz_reg;
                        ld_taken = 1'b1;
                        bs_next  = fst_reg;
                        if (strat_reg == FIT_NEXT)
                            cur_next = (NW'(fnd_reg) + NW'(1) < count_reg) ?
                                       fnd_reg + IW'(1) : '0;
                    end
                end
                else
                begin
                    state_next = S_MERGE;
                    mstep_next = 2'd0;
                end
            end
            S_MERGE:
            begin
                unique case (mstep_reg)
                    2'd3:
                    begin
                        // fill the split pair after the row opened its gap
                        ld_any   = 1'b1;
                        ld_idx   = fnd_reg;
                        ld_start = fst_reg;
                        ld_size  = SW'(rq_reg);
                        ld_taken = 1'b1;
                        mstep_next = 2'd2;
                    end
                    2'd2:
                    begin
                        ld_any   = 1'b1;
                        ld_idx   = fnd_reg + IW'(1);
                        ld_start = fst_reg + AW'(rq_reg);
                        ld_size  = fsz_reg - SW'(rq_reg);
                        ld_taken = 1'b0;
                        state_next = S_STAT;
                    end
                    2'd0:
                    begin
                        // free entry fnd, then fold a free right neighbor into it
                        ld_any   = 1'b1;
                        ld_idx   = fnd_reg;
                        ld_start = fst_reg;
                        ld_taken = 1'b0;
                        ld_size  = fsz_reg;
                        if (rfree_reg)
                        begin
                            ld_size    = fsz_reg + rz_reg;
                            fsz_next   = fsz_reg + rz_reg;
                            cmd        = CMD_DEL;
                            pos        = fnd_reg + IW'(1);
                            count_next = count_reg - NW'(1);
                            if (cur_reg >= fnd_reg + IW'(1))
                                cur_next = cur_reg - IW'(1);
                        end
                        mstep_next = 2'd1;
                    end
                    default:
                    begin
                        if (lfree_reg)
                        begin
                            ld_any   = 1'b1;
                            ld_idx   = fnd_reg - IW'(1);
                            ld_start = ls_reg;
                            ld_size  = lz_reg + fsz_reg;
                            ld_taken = 1'b0;
                            cmd        = CMD_DEL;
                            pos        = fnd_reg;
                            count_next = count_reg - NW'(1);
                            if (cur_reg >= fnd_reg)
                                cur_next = cur_reg - IW'(1);
                        end
                        state_next = S_STAT;
                    end
                endcase
                k_next = '0;
            end
            S_STAT:
            begin
                if (k_reg < count_reg)
                begin
                    if (c_taken[0])
                        ab_next = ab_reg + sz0;
                    else
                    begin
                        holes_next = holes_reg + CNT_W'(1);
                        fb_next    = fb_reg + sz0;
                        if (sz0 > lg_reg)
                            lg_next = sz0;
                        if (sz0 <= thr_reg)
                            small_next = small_reg + CNT_W'(1);
                    end
                    if (addr_reg >= c_start[0] && (SW+1)'(addr_reg) < pend)
                        probe_next = c_taken[0];
                    rot    = 1'b1;
                    k_next = k_reg + NW'(1);
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_STAT && k_reg == '0 && stat_reg != ST_OK)
            bs_next = '0;
    end

    // note: scan of state S_SCAN only rotates; direct loads index the unrotated table,
    // and a full rotation restores the order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= NW'(1);
            cur_reg    <= '0;
            ovalid_reg <= 1'b0;
            k_reg      <= '0;
            have_reg   <= 1'b0;
            mstep_reg  <= '0;
            grab_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            k_reg     <= k_next;
            have_reg  <= have_next;
            mstep_reg <= mstep_next;
            grab_reg  <= grab_next;
            if (state_reg == S_OUT)
                ovalid_reg <= 1'b1;
            else if (rsp.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.op;
            rq_reg   <= req.request_bytes;
            addr_reg <= AW'(req.address);
            thr_reg  <= req.threshold;
        end
        fnd_reg   <= fnd_next;
        fsz_reg   <= fsz_next;
        fst_reg   <= fst_next;
        stat_reg  <= stat_next;
        bs_reg    <= bs_next;
        holes_reg <= holes_next;
        small_reg <= small_next;
        ab_reg    <= ab_next;
        fb_reg    <= fb_next;
        lg_reg    <= lg_next;
        probe_reg <= probe_next;
        pvs_reg   <= pvs_next;
        pvz_reg   <= pvz_next;
        pvt_reg   <= pvt_next;
        ls_reg    <= ls_next;
        lz_reg    <= lz_next;
        lfree_reg <= lfree_next;
        rz_reg    <= rz_next;
        rfree_reg <= rfree_next;
    end

    assign rsp.valid            = ovalid_reg;
    assign rsp.status           = stat_reg;
    assign rsp.block_start      = ADDR_W'(bs_reg);
    assign rsp.hole_count       = holes_reg;
    assign rsp.bytes_allocated  = ab_reg;
    assign rsp.bytes_free       = fb_reg;
    assign rsp.largest_hole     = lg_reg;
    assign rsp.small_hole_count = small_reg;
    assign rsp.probe_allocated  = probe_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= NW'(1) && count_reg <= NW'(MAX_SEGMENTS))
        else $error("segment count out of range");
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !req.ready)
        else $error("input taken while result pending");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> ovalid_reg)
        else $error("result not posted");
endmodule
